@@ rtl/fpti_pkg.sv @@
// Shared types and constants for the four-point table interpolator.
package fpti_pkg;

  // Fixed field widths
  localparam int POS_W    = 29;
  localparam int LEN_W    = 13;
  localparam int WIDX_W   = 12;
  localparam int SAMPLE_W = 16;

  // Weight u: 16 fraction bits plus one integer bit for the value one
  localparam int UFRAC_W = 16;
  localparam int U_W     = UFRAC_W + 1;
  localparam logic [U_W-1:0] U_ONE = U_W'(1) << UFRAC_W;

  // Shortest table that can be interpolated
  localparam int MIN_LEN = 4;

  // Default parameter values
  localparam int DEF_TABLE_DEPTH   = 4096;
  localparam int DEF_FRACTION_BITS = 16;

  // Interleaved sample memory: four neighbors come from four banks
  localparam int BANKS  = 4;
  localparam int BANK_W = 2;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Datapath widths of the polynomial evaluation
  localparam int K1_W = SAMPLE_W + 1;
  localparam int K3_W = SAMPLE_W + 3;
  localparam int K2_W = SAMPLE_W + 4;
  localparam int P3_W = U_W + 1 + K3_W;
  localparam int H2_W = 38;
  localparam int P2_W = U_W + 1 + H2_W;
  localparam int S5_W = P2_W + 1;
  localparam int H1_W = 40;
  localparam int P1_W = U_W + 1 + H1_W;
  localparam int V_W  = P1_W + 1;
  localparam int OW_W = V_W - 33;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

  // Input mode codes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Command kinds handed from front to back
  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_ZERO
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [U_W-1:0]              frac;
  } cmd_t;

endpackage

@@ rtl/fpti_if.sv @@
// Valid/ready channel interfaces for the interpolator's input and result streams.
interface fpti_in_if;
  import fpti_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [WIDX_W-1:0]          write_index;
  logic signed [SAMPLE_W-1:0] write_sample;
  logic signed [POS_W-1:0]    read_position;

  modport source (
    output valid, mode, write_index, write_sample, read_position,
    input  ready
  );
  modport sink (
    input  valid, mode, write_index, write_sample, read_position,
    output ready
  );
endinterface

interface fpti_out_if;
  import fpti_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] interpolated_sample;

  modport source (
    output valid, interpolated_sample,
    input  ready
  );
  modport sink (
    input  valid, interpolated_sample,
    output ready
  );
endinterface

@@ rtl/fpti_front.sv @@
// Front end: accepts input transactions, holds table_length, clamps positions into commands.
module fpti_front #(
  parameter int TABLE_DEPTH   = fpti_pkg::DEF_TABLE_DEPTH,
  parameter int FRACTION_BITS = fpti_pkg::DEF_FRACTION_BITS,
  parameter int ADDR_W        = $clog2(TABLE_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  fpti_in_if.sink                      in_ch,
  input  logic                         cfg_write_enable,
  input  logic [fpti_pkg::LEN_W-1:0]   cfg_write_data,
  output logic                         push_valid,
  input  logic                         push_ready,
  output fpti_pkg::cmd_t               push_cmd,
  output logic [ADDR_W-1:0]            push_addr
);
  import fpti_pkg::*;

  localparam int IP_W = POS_W - FRACTION_BITS;
  localparam int CW   = ((IP_W > LEN_W) ? IP_W : LEN_W) + 1;

  logic [LEN_W-1:0]  table_length_r;
  logic [LEN_W-1:0]  len_eff;
  logic [CW-1:0]     int_part;
  logic [CW-1:0]     hi_lim;
  logic [CW-1:0]     idx;
  logic [U_W-1:0]    u_frac;
  logic              below_one;
  logic              past_end;
  logic              short_tab;
  logic              in_fire;
  logic              keep;
  cmd_t              cmd_nxt;
  logic [ADDR_W-1:0] addr_nxt;
  logic              front_valid_r;
  cmd_t              front_cmd_r;
  logic [ADDR_W-1:0] front_addr_r;

  // Fraction brought to 16 bits
  if (FRACTION_BITS >= UFRAC_W) begin : g_frac_trunc
    assign u_frac = {1'b0, in_ch.read_position[FRACTION_BITS-1 -: UFRAC_W]};
  end else begin : g_frac_pad
    assign u_frac = {1'b0, in_ch.read_position[FRACTION_BITS-1:0],
                     {(UFRAC_W - FRACTION_BITS){1'b0}}};
  end

  // Effective length and clamp limits
  always_comb begin
    if (32'(table_length_r) > 32'(TABLE_DEPTH)) begin
      len_eff = LEN_W'(TABLE_DEPTH);
    end else begin
      len_eff = table_length_r;
    end
    short_tab = len_eff < LEN_W'(MIN_LEN);
    hi_lim    = CW'(len_eff) - CW'(3);
    int_part  = CW'(in_ch.read_position[POS_W-1:FRACTION_BITS]);
    below_one = in_ch.read_position[POS_W-1] || (int_part == '0);
    past_end  = !below_one && (int_part > hi_lim);
    if (below_one) begin
      idx = CW'(1);
    end else if (past_end) begin
      idx = hi_lim;
    end else begin
      idx = int_part;
    end
  end

  // Classify the transaction into a command
  always_comb begin
    cmd_nxt.sample = in_ch.write_sample;
    cmd_nxt.frac   = u_frac;
    keep           = 1'b1;
    if (in_ch.mode == MODE_WRITE) begin
      cmd_nxt.kind = CMD_WRITE;
      addr_nxt     = ADDR_W'(in_ch.write_index);
      // writes beyond the table are dropped here
      keep         = 32'(in_ch.write_index) < 32'(TABLE_DEPTH);
    end else if (short_tab) begin
      cmd_nxt.kind = CMD_ZERO;
      addr_nxt     = '0;
    end else begin
      cmd_nxt.kind = CMD_READ;
      // base address is the leftmost of the four neighbors
      addr_nxt     = ADDR_W'(idx - CW'(1));
      if (below_one) begin
        cmd_nxt.frac = '0;
      end else if (past_end) begin
        cmd_nxt.frac = U_ONE;
      end
    end
  end

  assign in_ch.ready = !front_valid_r || push_ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r  <= 1'b0;
      table_length_r <= '0;
    end else begin
      if (cfg_write_enable) begin
        table_length_r <= cfg_write_data;
      end
      if (in_ch.ready) begin
        front_valid_r <= in_fire && keep;
      end
    end
  end

  // Command payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      front_cmd_r  <= cmd_nxt;
      front_addr_r <= addr_nxt;
    end
  end

  assign push_valid = front_valid_r;
  assign push_cmd   = front_cmd_r;
  assign push_addr  = front_addr_r;

endmodule

@@ rtl/fpti_queue.sv @@
// Short command queue that decouples the front end from the back end.
module fpti_queue #(
  parameter int ADDR_W = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  fpti_pkg::cmd_t      push_cmd,
  input  logic [ADDR_W-1:0]   push_addr,
  output logic                pop_valid,
  input  logic                pop_ready,
  output fpti_pkg::cmd_t      pop_cmd,
  output logic [ADDR_W-1:0]   pop_addr
);
  import fpti_pkg::*;

  cmd_t              q_cmd_r  [QUEUE_DEPTH];
  logic [ADDR_W-1:0] q_addr_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push_fire;
  logic              pop_fire;

  assign push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_cmd    = q_cmd_r[rd_ptr_r];
  assign pop_addr   = q_addr_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop_fire) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop_fire && !push_fire) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_fire) begin
      q_cmd_r[wr_ptr_r]  <= push_cmd;
      q_addr_r[wr_ptr_r] <= push_addr;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> rd_ptr_r == wr_ptr_r)
    else $error("empty queue with unequal pointers");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push_fire && !pop_fire |=> count_r == $past(count_r) + QCNT_W'(1))
    else $error("push without pop did not grow the queue");

endmodule

@@ rtl/fpti_back.sv @@
// Back end: banked sample memory and the pipelined cubic evaluation with output register.
module fpti_back #(
  parameter int TABLE_DEPTH = fpti_pkg::DEF_TABLE_DEPTH,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  fpti_pkg::cmd_t      pop_cmd,
  input  logic [ADDR_W-1:0]   pop_addr,
  fpti_out_if.source          out_ch
);
  import fpti_pkg::*;

  localparam int ROWS  = (TABLE_DEPTH + BANKS - 1) / BANKS;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic                       adv;
  logic                       pop_fire;
  logic                       wr_en;
  logic [BANK_W-1:0]          wr_bank;
  logic [ROW_W-1:0]           wr_row;
  logic [ROW_W-1:0]           rd_row  [BANKS];
  logic signed [SAMPLE_W-1:0] rd_q_r  [BANKS];

  // Stage 1: memory read
  logic                       s1_valid_r;
  logic                       s1_zero_r;
  logic [U_W-1:0]             s1_u_r;
  logic [BANK_W-1:0]          s1_sel_r;
  // Stage 2: coefficients
  logic                       s2_valid_r;
  logic                       s2_zero_r;
  logic [U_W-1:0]             s2_u_r;
  logic signed [SAMPLE_W-1:0] s2_b_r;
  logic signed [K1_W-1:0]     s2_k1_r;
  logic signed [K2_W-1:0]     s2_k2_r;
  logic signed [K3_W-1:0]     s2_k3_r;
  // Stage 3: u*k3
  logic                       s3_valid_r;
  logic                       s3_zero_r;
  logic [U_W-1:0]             s3_u_r;
  logic signed [SAMPLE_W-1:0] s3_b_r;
  logic signed [K1_W-1:0]     s3_k1_r;
  logic signed [K2_W-1:0]     s3_k2_r;
  logic signed [P3_W-1:0]     s3_p3_r;
  // Stage 4: u*h2
  logic                       s4_valid_r;
  logic                       s4_zero_r;
  logic [U_W-1:0]             s4_u_r;
  logic signed [SAMPLE_W-1:0] s4_b_r;
  logic signed [K1_W-1:0]     s4_k1_r;
  logic signed [P2_W-1:0]     s4_p2_r;
  // Stage 5: u*h1
  logic                       s5_valid_r;
  logic                       s5_zero_r;
  logic signed [SAMPLE_W-1:0] s5_b_r;
  logic signed [P1_W-1:0]     s5_p1_r;
  // Output register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  logic signed [SAMPLE_W-1:0] ta, tb, tc, td;
  logic signed [K1_W-1:0]     cb;
  logic signed [K1_W-1:0]     k1;
  logic signed [K3_W-1:0]     k3;
  logic signed [K2_W-1:0]     k2;
  logic signed [K2_W-1:0]     curv;
  logic signed [H2_W-1:0]     h2;
  logic signed [S5_W-1:0]     sum5;
  logic signed [H1_W-1:0]     h1;
  logic signed [V_W-1:0]      v;
  logic signed [OW_W-1:0]     out_wide;
  logic signed [SAMPLE_W-1:0] out_sat;

  // Whole pipeline moves when the output register is free or being taken
  assign adv       = !out_valid_r || out_ch.ready;
  assign pop_ready = adv;
  assign pop_fire  = pop_valid && adv;
  assign wr_en     = pop_fire && (pop_cmd.kind == CMD_WRITE);
  assign wr_bank   = pop_addr[BANK_W-1:0];
  assign wr_row    = ROW_W'(pop_addr >> BANK_W);

  // Four banks, entry e lives in bank e mod 4; four neighbors hit four banks
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic signed [SAMPLE_W-1:0] bank_mem [ROWS];
    logic [BANK_W-1:0]          offs;

    assign offs      = BANK_W'(b) - pop_addr[BANK_W-1:0];
    assign rd_row[b] = ROW_W'((pop_addr + ADDR_W'(offs)) >> BANK_W);

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == BANK_W'(b))) begin
        bank_mem[wr_row] <= pop_cmd.sample;
      end
      if (adv) begin
        rd_q_r[b] <= bank_mem[rd_row[b]];
      end
    end
  end

  // Reorder banks into a..d and form the polynomial coefficients
  always_comb begin
    ta   = rd_q_r[s1_sel_r];
    tb   = rd_q_r[s1_sel_r + BANK_W'(1)];
    tc   = rd_q_r[s1_sel_r + BANK_W'(2)];
    td   = rd_q_r[s1_sel_r + BANK_W'(3)];
    cb   = K1_W'(tc) - K1_W'(tb);
    k1   = K1_W'(tc) - K1_W'(ta);
    // k3 = d - a - 3(c - b)
    k3   = K3_W'(td) - K3_W'(ta) - K3_W'(cb) - (K3_W'(cb) <<< 1);
    curv = (K2_W'(tb) <<< 1) - K2_W'(ta) - K2_W'(tc);
    k2   = -K2_W'(k3) - curv;
  end

  // Horner steps, final rounding and saturation
  always_comb begin
    h2   = (H2_W'(s3_k2_r) <<< UFRAC_W) + H2_W'(s3_p3_r);
    sum5 = (S5_W'(s4_k1_r) <<< 32) + S5_W'(s4_p2_r);
    h1   = H1_W'(sum5 >>> UFRAC_W);
    v    = (V_W'(s5_b_r) <<< 33) + V_W'(s5_p1_r) + (V_W'(1) <<< 32);
    out_wide = OW_W'(v >>> 33);
    if (out_wide > OW_W'(SAMPLE_MAX)) begin
      out_sat = SAMPLE_MAX;
    end else if (out_wide < OW_W'(SAMPLE_MIN)) begin
      out_sat = SAMPLE_MIN;
    end else begin
      out_sat = SAMPLE_W'(out_wide);
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= pop_fire && (pop_cmd.kind != CMD_WRITE);
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      out_valid_r <= s5_valid_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_zero_r <= pop_cmd.kind == CMD_ZERO;
      s1_u_r    <= pop_cmd.frac;
      s1_sel_r  <= pop_addr[BANK_W-1:0];

      s2_zero_r <= s1_zero_r;
      s2_u_r    <= s1_u_r;
      s2_b_r    <= tb;
      s2_k1_r   <= k1;
      s2_k2_r   <= k2;
      s2_k3_r   <= k3;

      s3_zero_r <= s2_zero_r;
      s3_u_r    <= s2_u_r;
      s3_b_r    <= s2_b_r;
      s3_k1_r   <= s2_k1_r;
      s3_k2_r   <= s2_k2_r;
      s3_p3_r   <= P3_W'($signed({1'b0, s2_u_r})) * P3_W'(s2_k3_r);

      s4_zero_r <= s3_zero_r;
      s4_u_r    <= s3_u_r;
      s4_b_r    <= s3_b_r;
      s4_k1_r   <= s3_k1_r;
      s4_p2_r   <= P2_W'($signed({1'b0, s3_u_r})) * P2_W'(h2);

      s5_zero_r <= s4_zero_r;
      s5_b_r    <= s4_b_r;
      s5_p1_r   <= P1_W'($signed({1'b0, s4_u_r})) * P1_W'(h1);

      out_sample_r <= s5_zero_r ? '0 : out_sat;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.interpolated_sample = out_sample_r;

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> !s1_valid_r)
    else $error("table write entered the result pipeline");

  a_zero_flows: assert property (@(posedge clk) disable iff (!rst_n)
    pop_fire && (pop_cmd.kind == CMD_ZERO) |=> s1_valid_r && s1_zero_r)
    else $error("short-table read lost its zero flag");

  a_last_stage_out: assert property (@(posedge clk) disable iff (!rst_n)
    s5_valid_r && adv |=> out_valid_r)
    else $error("finished result did not reach the output register");

endmodule

@@ rtl/four_point_table_interpolator_core.sv @@
// Top level of the four-point cubic table interpolator.
//
// Channels: in_ch carries one transaction per item. mode 0 stores write_sample at
// write_index (indexes at or beyond TABLE_DEPTH are dropped, no result); mode 1
// reads the table at read_position (FRACTION_BITS fraction bits) and returns
// one interpolated_sample on out_ch. Clamping at both table ends and the short
// table case (length below four gives zero) are settled in the front end.
// cfg_write_enable/cfg_write_data set table_length; write it only while idle.
// Throughput: one transaction per cycle, sustained, as long as out_ch is taken;
// the four-bank interleaved memory delivers all four neighbors in one read.
// A read passes the front register, queue, back stages and output register.
// A table write is visible to any read accepted after it.
// A stalled out_ch holds the result and freezes the evaluation pipeline; the
// four-entry command queue and the front register then fill before in_ch.ready
// drops. Reset (rst_n low, synchronous) empties the pipeline and queue and
// clears table_length; the sample memory is not cleared and must be written
// before it is read.
module four_point_table_interpolator_core #(
  parameter int TABLE_DEPTH   = fpti_pkg::DEF_TABLE_DEPTH,
  parameter int FRACTION_BITS = fpti_pkg::DEF_FRACTION_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  fpti_in_if.sink                     in_ch,
  fpti_out_if.source                  out_ch,
  input  logic                        cfg_write_enable,
  input  logic [fpti_pkg::LEN_W-1:0]  cfg_write_data
);
  import fpti_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic              push_valid;
  logic              push_ready;
  cmd_t              push_cmd;
  logic [ADDR_W-1:0] push_addr;
  logic              pop_valid;
  logic              pop_ready;
  cmd_t              pop_cmd;
  logic [ADDR_W-1:0] pop_addr;

  // Accept and classify
  fpti_front #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS),
    .ADDR_W        (ADDR_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_cmd         (push_cmd),
    .push_addr        (push_addr)
  );

  // Decoupling queue
  fpti_queue #(
    .ADDR_W (ADDR_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .push_addr  (push_addr),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .pop_addr   (pop_addr)
  );

  // Memory and evaluation
  fpti_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .pop_addr  (pop_addr),
    .out_ch    (out_ch)
  );

endmodule
